// ===== rtl/uelb_pkg.sv =====
package uelb_pkg;

   localparam int BYTE_W      = 8;
   localparam int RX_DEPTH_DEF = 64;
   localparam int TX_DEPTH_DEF = 64;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   localparam logic [1:0] MODE_RX_BYTE  = 2'd0;
   localparam logic [1:0] MODE_TX_READY = 2'd1;
   localparam logic [1:0] MODE_HOST_TX  = 2'd2;
   localparam logic [1:0] MODE_READ_LN  = 2'd3;

   localparam logic [1:0] KIND_TX_BYTE  = 2'd0;
   localparam logic [1:0] KIND_TX_EMPTY = 2'd1;
   localparam logic [1:0] KIND_LINE_CH  = 2'd2;
   localparam logic [1:0] KIND_LINE_ST  = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_LINE  = 2'd1;
   localparam logic [1:0] ST_TOO_LONG = 2'd2;
   localparam logic [1:0] ST_ZERO_LIM = 2'd3;

   typedef enum logic [1:0] {
      RA_IDX,
      RA_NX,
      RA_RD
   } rx_addr_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_TX_WAIT,
      S_TX_EMIT,
      S_TX_NONE,
      S_ZERO_LIM,
      S_SCAN,
      S_SCAN_WAIT,
      S_PAIR_WAIT,
      S_DECIDE,
      S_NO_LINE,
      S_TOO_LONG,
      S_LINE_RD,
      S_LINE_WAIT,
      S_LINE_EMIT,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic            capture;
      logic            rx_push;
      logic            tx_push;
      logic            idx_load;
      logic            idx_inc;
      logic            len_inc;
      logic            len_dec;
      logic            rx_ren;
      rx_addr_sel_type rx_addr_sel;
      logic            c_save;
      logic            term_pair;
      logic            term_single;
      logic            rd_inc;
      logic            rd_skip;
      logic            tx_ren;
      logic            tx_rd_inc;
      logic            emit;
      logic [1:0]      emit_kind;
      logic [1:0]      emit_status;
      logic            emit_last;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       limit_zero;
      logic       tx_empty;
      logic       idx_at_wr;
      logic       nx_at_wr;
      logic       c_is_term;
      logic       len_ge_limit;
      logic       len_zero;
      logic       len_one;
      logic       out_free;
   } stat_type;

endpackage

// ===== rtl/uelb_ram.sv =====
module uelb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/uelb_datapath.sv =====
module uelb_datapath
   import uelb_pkg::*;
#(
   parameter int RX_DEPTH = RX_DEPTH_DEF,
   parameter int TX_DEPTH = TX_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [1:0]  in_mode,
   input  logic [7:0]  in_data,
   input  logic [7:0]  in_limit,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [1:0]  out_kind,
   output logic [7:0]  out_data,
   output logic [1:0]  out_status,
   output logic        out_last
);

   localparam int RX_PTR_W = $clog2(RX_DEPTH);
   localparam int TX_PTR_W = $clog2(TX_DEPTH);
   localparam logic [RX_PTR_W-1:0] RX_TOP = RX_PTR_W'(RX_DEPTH - 1);
   localparam logic [TX_PTR_W-1:0] TX_TOP = TX_PTR_W'(TX_DEPTH - 1);

   logic [1:0]          mode_ff, mode_in;
   logic [7:0]          data_ff, data_in;
   logic [7:0]          limit_ff, limit_in;
   logic [RX_PTR_W-1:0] rx_wr_ff, rx_wr_in, rx_rd_ff, rx_rd_in;
   logic [RX_PTR_W-1:0] idx_ff, idx_in, len_ff, len_in;
   logic [TX_PTR_W-1:0] tx_wr_ff, tx_wr_in, tx_rd_ff, tx_rd_in;
   logic [7:0]          c_ff, c_in;
   logic                term2_ff, term2_in;
   logic                valid_ff, valid_in;
   logic [1:0]          kind_ff, kind_in;
   logic [7:0]          odata_ff, odata_in;
   logic [1:0]          ostat_ff, ostat_in;
   logic                olast_ff, olast_in;

   logic [RX_PTR_W-1:0] idx1, idx2, rx_wr1, rx_rd1, rx_raddr;
   logic [TX_PTR_W-1:0] tx_wr1, tx_rd1;
   logic                rx_full, tx_full, rx_we, tx_we, pair;
   logic [7:0]          rx_rdata, tx_rdata;

   assign idx1   = (idx_ff == RX_TOP) ? '0 : idx_ff + 1'b1;
   assign idx2   = (idx1 == RX_TOP) ? '0 : idx1 + 1'b1;
   assign rx_wr1 = (rx_wr_ff == RX_TOP) ? '0 : rx_wr_ff + 1'b1;
   assign rx_rd1 = (rx_rd_ff == RX_TOP) ? '0 : rx_rd_ff + 1'b1;
   assign tx_wr1 = (tx_wr_ff == TX_TOP) ? '0 : tx_wr_ff + 1'b1;
   assign tx_rd1 = (tx_rd_ff == TX_TOP) ? '0 : tx_rd_ff + 1'b1;

   assign rx_full = (rx_wr1 == rx_rd_ff);
   assign tx_full = (tx_wr1 == tx_rd_ff);
   assign rx_we   = cmd.rx_push && !rx_full;
   assign tx_we   = cmd.tx_push && !tx_full;
   assign pair    = (c_ff == CH_CR && rx_rdata == CH_LF) ||
                    (c_ff == CH_LF && rx_rdata == CH_CR);

   always_comb begin
      case (cmd.rx_addr_sel)
         RA_IDX:  rx_raddr = idx_ff;
         RA_NX:   rx_raddr = idx1;
         RA_RD:   rx_raddr = rx_rd_ff;
         default: rx_raddr = idx_ff;
      endcase
   end

   uelb_ram #(.WIDTH(BYTE_W), .DEPTH(RX_DEPTH)) u_rx_ram (
      .clock (clock),
      .we    (rx_we),
      .waddr (rx_wr_ff),
      .wdata (data_ff),
      .re    (cmd.rx_ren),
      .raddr (rx_raddr),
      .rdata (rx_rdata)
   );

   uelb_ram #(.WIDTH(BYTE_W), .DEPTH(TX_DEPTH)) u_tx_ram (
      .clock (clock),
      .we    (tx_we),
      .waddr (tx_wr_ff),
      .wdata (data_ff),
      .re    (cmd.tx_ren),
      .raddr (tx_rd_ff),
      .rdata (tx_rdata)
   );

   always_comb begin
      mode_in  = cmd.capture ? in_mode : mode_ff;
      data_in  = cmd.capture ? in_data : data_ff;
      limit_in = cmd.capture ? in_limit : limit_ff;

      rx_wr_in = rx_we ? rx_wr1 : rx_wr_ff;
      tx_wr_in = tx_we ? tx_wr1 : tx_wr_ff;
      tx_rd_in = cmd.tx_rd_inc ? tx_rd1 : tx_rd_ff;

      rx_rd_in = rx_rd_ff;
      if (cmd.rd_inc) begin
         rx_rd_in = rx_rd1;
      end else if (cmd.rd_skip) begin
         rx_rd_in = term2_ff ? idx2 : idx1;
      end

      idx_in = idx_ff;
      if (cmd.idx_load) begin
         idx_in = rx_rd_ff;
      end else if (cmd.idx_inc) begin
         idx_in = idx1;
      end

      len_in = len_ff;
      if (cmd.idx_load) begin
         len_in = '0;
      end else if (cmd.len_inc) begin
         len_in = len_ff + 1'b1;
      end else if (cmd.len_dec) begin
         len_in = len_ff - 1'b1;
      end

      c_in = cmd.c_save ? rx_rdata : c_ff;

      term2_in = term2_ff;
      if (cmd.term_pair) begin
         term2_in = pair;
      end else if (cmd.term_single) begin
         term2_in = 1'b0;
      end

      valid_in = valid_ff && !out_ready;
      kind_in  = kind_ff;
      odata_in = odata_ff;
      ostat_in = ostat_ff;
      olast_in = olast_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
         kind_in  = cmd.emit_kind;
         ostat_in = cmd.emit_status;
         olast_in = cmd.emit_last;
         case (cmd.emit_kind)
            KIND_TX_BYTE: odata_in = tx_rdata;
            KIND_LINE_CH: odata_in = rx_rdata;
            default:      odata_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_wr_ff <= '0;
         rx_rd_ff <= '0;
         tx_wr_ff <= '0;
         tx_rd_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         rx_wr_ff <= rx_wr_in;
         rx_rd_ff <= rx_rd_in;
         tx_wr_ff <= tx_wr_in;
         tx_rd_ff <= tx_rd_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      data_ff  <= data_in;
      limit_ff <= limit_in;
      idx_ff   <= idx_in;
      len_ff   <= len_in;
      c_ff     <= c_in;
      term2_ff <= term2_in;
      kind_ff  <= kind_in;
      odata_ff <= odata_in;
      ostat_ff <= ostat_in;
      olast_ff <= olast_in;
   end

   always_comb begin
      stat.mode         = mode_ff;
      stat.limit_zero   = (limit_ff == '0);
      stat.tx_empty     = (tx_wr_ff == tx_rd_ff);
      stat.idx_at_wr    = (idx_ff == rx_wr_ff);
      stat.nx_at_wr     = (idx1 == rx_wr_ff);
      stat.c_is_term    = (rx_rdata == CH_CR) || (rx_rdata == CH_LF);
      stat.len_ge_limit = ({{(BYTE_W - RX_PTR_W){1'b0}}, len_ff} >= limit_ff);
      stat.len_zero     = (len_ff == '0);
      stat.len_one      = (len_ff == RX_PTR_W'(1));
      stat.out_free     = !valid_ff || out_ready;
   end

   assign out_valid  = valid_ff;
   assign out_kind   = kind_ff;
   assign out_data   = odata_ff;
   assign out_status = ostat_ff;
   assign out_last   = olast_ff;

endmodule

// ===== rtl/uelb_ctrl.sv =====
module uelb_ctrl
   import uelb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            case (stat.mode)
               MODE_RX_BYTE:  state_in = S_IDLE;
               MODE_HOST_TX:  state_in = S_IDLE;
               MODE_TX_READY: state_in = stat.tx_empty ? S_TX_NONE : S_TX_WAIT;
               default:       state_in = stat.limit_zero ? S_ZERO_LIM : S_SCAN;
            endcase
         end
         S_TX_WAIT: state_in = S_TX_EMIT;
         S_TX_EMIT, S_TX_NONE, S_ZERO_LIM, S_NO_LINE, S_TOO_LONG, S_FINISH: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         S_SCAN: state_in = stat.idx_at_wr ? S_NO_LINE : S_SCAN_WAIT;
         S_SCAN_WAIT: begin
            if (!stat.c_is_term) begin
               state_in = S_SCAN;
            end else if (stat.nx_at_wr) begin
               state_in = S_DECIDE;
            end else begin
               state_in = S_PAIR_WAIT;
            end
         end
         S_PAIR_WAIT: state_in = S_DECIDE;
         S_DECIDE: begin
            if (stat.len_ge_limit) begin
               state_in = S_TOO_LONG;
            end else if (stat.len_zero) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_LINE_RD;
            end
         end
         S_LINE_RD:   state_in = S_LINE_WAIT;
         S_LINE_WAIT: state_in = S_LINE_EMIT;
         S_LINE_EMIT: begin
            if (stat.out_free) state_in = stat.len_one ? S_FINISH : S_LINE_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.rx_addr_sel = RA_IDX;
      in_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            in_ready    = 1'b1;
            cmd.capture = in_valid;
         end
         S_DISPATCH: begin
            case (stat.mode)
               MODE_RX_BYTE: begin
                  cmd.rx_push = 1'b1;
                  cmd.tx_push = 1'b1;
               end
               MODE_HOST_TX:  cmd.tx_push = 1'b1;
               MODE_TX_READY: cmd.tx_ren = !stat.tx_empty;
               default:       cmd.idx_load = 1'b1;
            endcase
         end
         S_TX_EMIT: begin
            cmd.emit      = stat.out_free;
            cmd.tx_rd_inc = stat.out_free;
            cmd.emit_kind = KIND_TX_BYTE;
            cmd.emit_last = 1'b1;
         end
         S_TX_NONE: begin
            cmd.emit      = stat.out_free;
            cmd.emit_kind = KIND_TX_EMPTY;
            cmd.emit_last = 1'b1;
         end
         S_ZERO_LIM: begin
            cmd.emit        = stat.out_free;
            cmd.emit_kind   = KIND_LINE_ST;
            cmd.emit_status = ST_ZERO_LIM;
            cmd.emit_last   = 1'b1;
         end
         S_NO_LINE: begin
            cmd.emit        = stat.out_free;
            cmd.emit_kind   = KIND_LINE_ST;
            cmd.emit_status = ST_NO_LINE;
            cmd.emit_last   = 1'b1;
         end
         S_TOO_LONG: begin
            cmd.emit        = stat.out_free;
            cmd.rd_skip     = stat.out_free;
            cmd.emit_kind   = KIND_LINE_ST;
            cmd.emit_status = ST_TOO_LONG;
            cmd.emit_last   = 1'b1;
         end
         S_FINISH: begin
            cmd.emit        = stat.out_free;
            cmd.rd_skip     = stat.out_free;
            cmd.emit_kind   = KIND_LINE_ST;
            cmd.emit_status = ST_OK;
            cmd.emit_last   = 1'b1;
         end
         S_SCAN: begin
            cmd.rx_ren      = !stat.idx_at_wr;
            cmd.rx_addr_sel = RA_IDX;
         end
         S_SCAN_WAIT: begin
            if (!stat.c_is_term) begin
               cmd.len_inc = 1'b1;
               cmd.idx_inc = 1'b1;
            end else begin
               cmd.c_save = 1'b1;
               if (stat.nx_at_wr) begin
                  cmd.term_single = 1'b1;
               end else begin
                  cmd.rx_ren      = 1'b1;
                  cmd.rx_addr_sel = RA_NX;
               end
            end
         end
         S_PAIR_WAIT: cmd.term_pair = 1'b1;
         S_LINE_RD: begin
            cmd.rx_ren      = 1'b1;
            cmd.rx_addr_sel = RA_RD;
         end
         S_LINE_EMIT: begin
            cmd.emit      = stat.out_free;
            cmd.rd_inc    = stat.out_free;
            cmd.len_dec   = stat.out_free;
            cmd.emit_kind = KIND_LINE_CH;
         end
         default: cmd = '0;
      endcase
   end

endmodule

// ===== rtl/uart_echo_line_buffer_unit.sv =====
// Serial front end: receive ring with echo into a transmit ring, plus line reader.
// req channel: one word per event, tuser selects the event (received byte,
// transmitter ready, host send byte, read line); tdata carries the byte and
// the line buffer size. rsp channel: result words, tuser is the result kind,
// tlast marks the final result of the event.
// Events are handled one at a time; req_tready is high only when the
// controller is idle. Byte pushes give no result.
// Transmitter ready: a byte result goes through the RAM read, then the output
// register; an empty transmit ring gives the empty result.
// Read line: the scan reads each byte up to and including the terminator,
// plus the byte after the terminator when one follows, then each returned
// character is read and emitted, then the status word, all paced by the
// single registered read port of the receive RAM.
// The result register holds a word while rsp_tready is low; a new request is
// still taken, and the controller waits only when it must emit into a full
// result register. Reset empties both rings and the result register;
// RAM contents are not cleared and need no clearing pass.
module uart_echo_line_buffer_unit
   import uelb_pkg::*;
#(
   parameter int RX_DEPTH = RX_DEPTH_DEF,
   parameter int TX_DEPTH = TX_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // data[7:0], line_limit[15:8]
   input  logic [1:0]  req_tuser,  // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // data_res[7:0], status[9:8], zero pad
   output logic [1:0]  rsp_tuser,  // kind[1:0]
   output logic        rsp_tlast
);

   cmd_type    cmd;
   stat_type   stat;
   logic [7:0] out_data;
   logic [1:0] out_status;

   uelb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .stat     (stat),
      .cmd      (cmd)
   );

   uelb_datapath #(.RX_DEPTH(RX_DEPTH), .TX_DEPTH(TX_DEPTH)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .in_mode    (req_tuser),
      .in_data    (req_tdata[7:0]),
      .in_limit   (req_tdata[15:8]),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_kind   (rsp_tuser),
      .out_data   (out_data),
      .out_status (out_status),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {6'b0, out_status, out_data};

endmodule

// ===== rtl/uelb_checker.sv =====
module uelb_checker
   import uelb_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
         $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != KIND_LINE_CH)))
      else $error("tlast does not match result kind");

   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_TX_EMPTY || rsp_tuser == KIND_LINE_ST)
         |-> rsp_tdata[7:0] == 8'h00)
      else $error("nonzero data on empty or status word");

   a_zero_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_LINE_ST |-> rsp_tdata[15:8] == 8'h00)
      else $error("status set on non-status word");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind uart_echo_line_buffer_unit uelb_checker u_uelb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
